FILE: hdl/gsde_pkg.sv
// Shared types, constants and lane command struct for the gate stream depth tracker.
package gsde_pkg;

  // Table sizes
  localparam int QUBIT_LANES     = 32;
  localparam int MAX_GATE_QUBITS = 3;
  localparam int NUM_KINDS       = 64;
  localparam int LAYER_BITS      = 20;

  // Fixed field widths of the input and result words
  localparam int OP_W        = 2;
  localparam int KIND_W      = 6;
  localparam int QCNT_W      = 2;
  localparam int QUBIT_W     = 5;
  localparam int MASK_OUT_W  = 32;
  localparam int LAYER_OUT_W = 20;
  localparam int COUNT_W     = 32;

  // Derived widths
  localparam int QIDX_W  = $clog2(QUBIT_LANES);
  localparam int KADDR_W = $clog2(NUM_KINDS);
  localparam int CMP_W   = 9;

  // Merge tree shape: first stage reduces groups, second stage reduces the groups
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (QUBIT_LANES + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_APPLY      = 2'd0,
    OP_READ_QUBIT = 2'd1,
    OP_READ_KIND  = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef logic [QUBIT_LANES-1:0] mask_t;
  typedef logic [LAYER_BITS-1:0] layer_t;
  typedef logic [COUNT_W-1:0]    count_t;

  localparam layer_t LAYER_MAX = '1;
  localparam count_t COUNT_MAX = '1;

  // Command broadcast from the sequencer to every qubit lane
  typedef struct packed {
    logic                 capture;
    logic                 write;
    logic                 clear;
    op_t                  op;
    logic [QCNT_W-1:0]    qcount;
    logic [QUBIT_W-1:0]   qa;
    logic [QUBIT_W-1:0]   qb;
    logic [QUBIT_W-1:0]   qc;
    mask_t                new_mask;
    layer_t               new_layer;
  } lane_cmd_t;

endpackage

FILE: hdl/gsde_if.sv
// Valid/ready channel interfaces for gate words and result words.
interface gsde_in_if;
  import gsde_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [KIND_W-1:0]    gate_kind;
  logic [QCNT_W-1:0]    qubit_count;
  logic [QUBIT_W-1:0]   qubit_a;
  logic [QUBIT_W-1:0]   qubit_b;
  logic [QUBIT_W-1:0]   qubit_c;

  modport source (
    output valid, operation, gate_kind, qubit_count, qubit_a, qubit_b, qubit_c,
    input  ready
  );
  modport sink (
    input  valid, operation, gate_kind, qubit_count, qubit_a, qubit_b, qubit_c,
    output ready
  );
endinterface

interface gsde_out_if;
  import gsde_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [MASK_OUT_W-1:0]  entangled_mask;
  logic [LAYER_OUT_W-1:0] layer;
  logic [COUNT_W-1:0]     kind_count;

  modport source (
    output valid, entangled_mask, layer, kind_count,
    input  ready
  );
  modport sink (
    input  valid, entangled_mask, layer, kind_count,
    output ready
  );
endinterface

FILE: hdl/gsde_lane.sv
// One qubit lane: holds the qubit's mask and layer and taps them out when selected.
module gsde_lane import gsde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [QIDX_W-1:0] lane_id,
  input  lane_cmd_t         cmd,
  output mask_t             tap_mask,
  output layer_t            tap_layer
);

  mask_t  mask;
  layer_t layer;
  logic   hit_q;
  logic   sel_a;
  logic   sel_b;
  logic   sel_c;
  logic   hit;
  mask_t  own_bit;

  assign own_bit = mask_t'(1) << lane_id;

  // Decide whether this lane takes part in the current word
  always_comb begin
    sel_a = CMP_W'(cmd.qa) == CMP_W'(lane_id);
    sel_b = CMP_W'(cmd.qb) == CMP_W'(lane_id);
    sel_c = CMP_W'(cmd.qc) == CMP_W'(lane_id);
    unique case (cmd.op)
      OP_APPLY: begin
        hit = (sel_a && (cmd.qcount >= 2'd1) && (MAX_GATE_QUBITS >= 1)) ||
              (sel_b && (cmd.qcount >= 2'd2) && (MAX_GATE_QUBITS >= 2)) ||
              (sel_c && (cmd.qcount >= 2'd3) && (MAX_GATE_QUBITS >= 3));
      end
      OP_READ_QUBIT: hit = sel_a;
      OP_READ_KIND:  hit = 1'b0;
      OP_CLEAR:      hit = 1'b0;
    endcase
  end

  // Hold lane state; restore own bit on reset or clear, update on write-back
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mask  <= own_bit;
      layer <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd.capture) begin
        hit_q <= hit;
      end
      if (cmd.write && hit_q) begin
        mask  <= cmd.new_mask;
        layer <= cmd.new_layer;
      end
    end
  end

  // Tap the entry toward the merge tree, zero when not selected
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tap_mask  <= hit ? mask : '0;
      tap_layer <= hit ? layer : '0;
    end
  end

endmodule

FILE: hdl/gsde_merge.sv
// Two-stage registered tree: OR of lane masks and maximum of lane layers.
module gsde_merge import gsde_pkg::*; (
  input  logic   clk,
  input  mask_t  tap_mask  [QUBIT_LANES],
  input  layer_t tap_layer [QUBIT_LANES],
  output mask_t  merged_mask,
  output layer_t top_layer
);

  mask_t  pad_mask  [NUM_GROUPS][GROUP_SIZE];
  layer_t pad_layer [NUM_GROUPS][GROUP_SIZE];
  mask_t  part_mask_d  [NUM_GROUPS];
  layer_t part_layer_d [NUM_GROUPS];
  mask_t  part_mask  [NUM_GROUPS];
  layer_t part_layer [NUM_GROUPS];
  mask_t  all_mask_d;
  layer_t all_layer_d;

  // Pad the lane taps out to whole groups
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_elem
      if (g * GROUP_SIZE + k < QUBIT_LANES) begin : g_real
        assign pad_mask[g][k]  = tap_mask[g * GROUP_SIZE + k];
        assign pad_layer[g][k] = tap_layer[g * GROUP_SIZE + k];
      end else begin : g_pad
        assign pad_mask[g][k]  = '0;
        assign pad_layer[g][k] = '0;
      end
    end
  end

  // Reduce each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_mask_d[g]  = '0;
      part_layer_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        part_mask_d[g] = part_mask_d[g] | pad_mask[g][k];
        if (pad_layer[g][k] > part_layer_d[g]) begin
          part_layer_d[g] = pad_layer[g][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    part_mask  <= part_mask_d;
    part_layer <= part_layer_d;
  end

  // Reduce the group results
  always_comb begin
    all_mask_d  = '0;
    all_layer_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      all_mask_d = all_mask_d | part_mask[g];
      if (part_layer[g] > all_layer_d) begin
        all_layer_d = part_layer[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    merged_mask <= all_mask_d;
    top_layer   <= all_layer_d;
  end

endmodule

FILE: hdl/gsde_kind_mem.sv
// Per-kind gate count memory with valid bits that read unwritten entries as zero.
module gsde_kind_mem import gsde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               rd_en,
  input  logic [KADDR_W-1:0] rd_addr,
  input  logic               wr_en,
  input  logic [KADDR_W-1:0] wr_addr,
  input  count_t             wr_data,
  output count_t             rd_data
);

  count_t               mem [NUM_KINDS];
  logic [NUM_KINDS-1:0] valid;
  count_t               rd_word;
  logic                 rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: hdl/gate_stream_depth_and_entanglement.sv
// Top level: gate word sequencer, qubit lanes, merge tree, kind counts and result register.
// A result word is loaded out of write-back once its gate word has passed the lane tap and merge stages.
// Only one word is in flight at a time: the lanes tap, the merge tree takes two
// registered stages, then write-back loads the result register.
// A stalled result register holds the sequencer in its write-back state.
// Reset (rst, synchronous): lanes return to own-bit masks and zero layers,
// all kind counts read as zero, no result is pending; usable the next cycle.
module gate_stream_depth_and_entanglement import gsde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gsde_in_if.sink     gate_in,
  gsde_out_if.source  result_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RED1,
    S_RED2,
    S_WRITE
  } state_t;

  state_t               state;
  logic                 accept;
  logic                 out_free;
  logic                 out_valid;
  logic [MASK_OUT_W-1:0]  out_mask;
  logic [LAYER_OUT_W-1:0] out_layer;
  count_t               out_count;

  op_t                  cmd_op;
  logic [QCNT_W-1:0]    cmd_qcount;
  logic [QUBIT_W-1:0]   cmd_qa;
  logic [QUBIT_W-1:0]   cmd_qb;
  logic [QUBIT_W-1:0]   cmd_qc;
  logic [KADDR_W-1:0]   cmd_kind_addr;
  logic                 cmd_kind_ok;

  lane_cmd_t            lane_cmd;
  mask_t                tap_mask  [QUBIT_LANES];
  layer_t               tap_layer [QUBIT_LANES];
  mask_t                merged_mask;
  layer_t               top_layer;
  layer_t               new_layer;
  count_t               kind_rd_data;
  count_t               cur_count;
  count_t               new_count;
  logic                 commit;
  logic                 kind_wr;

  logic [MASK_OUT_W-1:0]  res_mask;
  logic [LAYER_OUT_W-1:0] res_layer;
  count_t               res_count;

  assign accept        = gate_in.valid && gate_in.ready;
  assign gate_in.ready = (state == S_IDLE);
  assign out_free      = !out_valid || result_out.ready;
  assign commit        = (state == S_WRITE) && out_free;

  // Latch the accepted gate word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op        <= op_t'(gate_in.operation);
      cmd_qcount    <= gate_in.qubit_count;
      cmd_qa        <= gate_in.qubit_a;
      cmd_qb        <= gate_in.qubit_b;
      cmd_qc        <= gate_in.qubit_c;
      cmd_kind_addr <= KADDR_W'(gate_in.gate_kind);
      cmd_kind_ok   <= CMP_W'(gate_in.gate_kind) < CMP_W'(NUM_KINDS);
    end
  end

  // Saturating layer and count updates
  always_comb begin
    new_layer = (top_layer == LAYER_MAX) ? top_layer : top_layer + 1'b1;
    cur_count = cmd_kind_ok ? kind_rd_data : '0;
    new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
  end

  // Broadcast to the lanes
  always_comb begin
    lane_cmd.capture   = (state == S_LOOK);
    lane_cmd.clear     = (state == S_LOOK) && (cmd_op == OP_CLEAR);
    lane_cmd.write     = commit && (cmd_op == OP_APPLY);
    lane_cmd.op        = cmd_op;
    lane_cmd.qcount    = cmd_qcount;
    lane_cmd.qa        = cmd_qa;
    lane_cmd.qb        = cmd_qb;
    lane_cmd.qc        = cmd_qc;
    lane_cmd.new_mask  = merged_mask;
    lane_cmd.new_layer = new_layer;
  end

  for (genvar i = 0; i < QUBIT_LANES; i++) begin : g_lane
    gsde_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .lane_id   (QIDX_W'(i)),
      .cmd       (lane_cmd),
      .tap_mask  (tap_mask[i]),
      .tap_layer (tap_layer[i])
    );
  end

  gsde_merge u_merge (
    .clk         (clk),
    .tap_mask    (tap_mask),
    .tap_layer   (tap_layer),
    .merged_mask (merged_mask),
    .top_layer   (top_layer)
  );

  assign kind_wr = commit && (cmd_op == OP_APPLY) && cmd_kind_ok;

  gsde_kind_mem u_kind_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (lane_cmd.clear),
    .rd_en   (accept),
    .rd_addr (KADDR_W'(gate_in.gate_kind)),
    .wr_en   (kind_wr),
    .wr_addr (cmd_kind_addr),
    .wr_data (new_count),
    .rd_data (kind_rd_data)
  );

  // Select the result fields for the operation
  always_comb begin
    res_mask  = '0;
    res_layer = '0;
    res_count = '0;
    unique case (cmd_op)
      OP_APPLY: begin
        res_mask  = MASK_OUT_W'(merged_mask);
        res_layer = LAYER_OUT_W'(new_layer);
        res_count = cmd_kind_ok ? new_count : '0;
      end
      OP_READ_QUBIT: begin
        res_mask  = MASK_OUT_W'(merged_mask);
        res_layer = LAYER_OUT_W'(top_layer);
      end
      OP_READ_KIND: begin
        res_count = cur_count;
      end
      OP_CLEAR: begin
        res_count = '0;
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (accept) state <= S_LOOK;
        S_LOOK:  state <= S_RED1;
        S_RED1:  state <= S_RED2;
        S_RED2:  state <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            out_mask  <= res_mask;
            out_layer <= res_layer;
            out_count <= res_count;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.entangled_mask = out_mask;
  assign result_out.layer          = out_layer;
  assign result_out.kind_count     = out_count;

  // An accepted word reaches write-back after the fixed tap and merge stages
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 (state == S_WRITE))
    else $error("gate word did not reach write-back on time");

  // Lane write-back only for an apply, only when the result can be loaded
  a_write_apply: assert property (@(posedge clk) disable iff (rst)
    lane_cmd.write |-> (cmd_op == OP_APPLY) && out_free && (state == S_WRITE))
    else $error("lane write-back outside an apply commit");

  // Clear happens only for a clear word, never together with a write
  a_clear_only: assert property (@(posedge clk) disable iff (rst)
    lane_cmd.clear |-> (cmd_op == OP_CLEAR) && !lane_cmd.write && !kind_wr)
    else $error("clear issued with a write or for another operation");

  // A new result appears only out of write-back
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WRITE))
    else $error("result loaded outside write-back");

  // No new word is taken while one is still in the lanes or merge tree
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !gate_in.ready)
    else $error("gate word accepted while another is in flight");

endmodule

FILE: bench/gate_stream_depth_and_entanglement_tb.sv
// Self-checking bench for the gate stream depth and entanglement tracker.
module gate_stream_depth_and_entanglement_tb;
  import gsde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t                op;
    logic [KIND_W-1:0]  kind;
    logic [QCNT_W-1:0]  qcount;
    logic [QUBIT_W-1:0] qa;
    logic [QUBIT_W-1:0] qb;
    logic [QUBIT_W-1:0] qc;
    bit                 drain;  // hold this word until every result is back
  } gate_word_t;

  typedef struct {
    logic [MASK_OUT_W-1:0]  mask;
    logic [LAYER_OUT_W-1:0] layer;
    logic [COUNT_W-1:0]     count;
  } tracker_result_t;

  logic clk;
  logic rst;

  gsde_in_if  gate_in();
  gsde_out_if result_out();

  gate_stream_depth_and_entanglement u_top (
    .clk        (clk),
    .rst        (rst),
    .gate_in    (gate_in),
    .result_out (result_out)
  );

  // Mirror of the tracker tables
  mask_t  qubit_masks  [QUBIT_LANES];
  layer_t qubit_depths [QUBIT_LANES];
  count_t kind_tallies [NUM_KINDS];

  gate_word_t      pending_gates[$];
  tracker_result_t gate_results[$];
  gate_word_t      cur_gate;
  int unsigned     mismatches;
  int unsigned     send_gap;
  int unsigned     send_burst;
  int unsigned     stall_left;
  int unsigned     quiet_left;

  // Restore the tables to their reset contents
  function automatic void clear_tables();
    for (int i = 0; i < QUBIT_LANES; i++) begin
      qubit_masks[i]  = '0;
      qubit_masks[i][i] = 1'b1;
      qubit_depths[i] = '0;
    end
    for (int i = 0; i < NUM_KINDS; i++) kind_tallies[i] = '0;
  endfunction

  // Update the tables for one word and return the result it should produce
  function automatic tracker_result_t track_gate(gate_word_t w);
    tracker_result_t r;
    mask_t           merged;
    layer_t          top;
    layer_t          depth;
    int              n;
    int              q;
    merged = '0;
    top    = '0;
    depth  = '0;
    r.mask  = '0;
    r.layer = '0;
    r.count = '0;
    n = (w.qcount > MAX_GATE_QUBITS) ? MAX_GATE_QUBITS : int'(w.qcount);
    case (w.op)
      OP_APPLY: begin
        // Merge masks and take the deepest layer; repeats are harmless
        for (int i = 0; i < n; i++) begin
          q = int'((i == 0) ? w.qa : (i == 1) ? w.qb : w.qc);
          if (q < QUBIT_LANES) begin
            merged |= qubit_masks[q];
            if (qubit_depths[q] > top) top = qubit_depths[q];
          end
        end
        depth = (top == LAYER_MAX) ? LAYER_MAX : top + 1'b1;
        for (int i = 0; i < n; i++) begin
          q = int'((i == 0) ? w.qa : (i == 1) ? w.qb : w.qc);
          if (q < QUBIT_LANES) begin
            qubit_masks[q]  = merged;
            qubit_depths[q] = depth;
          end
        end
        if (w.kind < NUM_KINDS) begin
          if (kind_tallies[w.kind] != COUNT_MAX) kind_tallies[w.kind]++;
          r.count = kind_tallies[w.kind];
        end
        r.mask  = MASK_OUT_W'(merged);
        r.layer = LAYER_OUT_W'(depth);
      end
      OP_READ_QUBIT: begin
        if (w.qa < QUBIT_LANES) begin
          r.mask  = MASK_OUT_W'(qubit_masks[w.qa]);
          r.layer = LAYER_OUT_W'(qubit_depths[w.qa]);
        end
      end
      OP_READ_KIND: begin
        if (w.kind < NUM_KINDS) r.count = kind_tallies[w.kind];
      end
      default: clear_tables();
    endcase
    return r;
  endfunction

  function automatic gate_word_t make_gate(op_t op, int kind, int qcount,
                                           int qa, int qb, int qc);
    gate_word_t w;
    w.op     = op;
    w.kind   = KIND_W'(kind);
    w.qcount = QCNT_W'(qcount);
    w.qa     = QUBIT_W'(qa);
    w.qb     = QUBIT_W'(qb);
    w.qc     = QUBIT_W'(qc);
    w.drain  = 1'b0;
    return w;
  endfunction

  // Mostly no idle, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst                  = 1'b1;
    gate_in.valid        = 1'b0;
    gate_in.operation    = OP_APPLY;
    gate_in.gate_kind    = '0;
    gate_in.qubit_count  = '0;
    gate_in.qubit_a      = '0;
    gate_in.qubit_b      = '0;
    gate_in.qubit_c      = '0;
    result_out.ready     = 1'b0;
  end

  // Driver: present queued words, predict on acceptance
  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      gate_in.valid <= 1'b0;
      send_gap   = 0;
      send_burst = 0;
    end else begin
      fire = gate_in.valid && gate_in.ready;
      if (fire) begin
        gate_results.push_back(track_gate(cur_gate));
        if (send_burst > 0) begin
          send_burst--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 99) < 3) send_burst = $urandom_range(20, 60);
        end
      end
      if (gate_in.valid && !fire) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        gate_in.valid <= 1'b0;
      end else if (pending_gates.size() > 0 &&
                   !(pending_gates[0].drain && gate_results.size() > 0)) begin
        cur_gate = pending_gates.pop_front();
        gate_in.operation   <= cur_gate.op;
        gate_in.gate_kind   <= cur_gate.kind;
        gate_in.qubit_count <= cur_gate.qcount;
        gate_in.qubit_a     <= cur_gate.qa;
        gate_in.qubit_b     <= cur_gate.qb;
        gate_in.qubit_c     <= cur_gate.qc;
        gate_in.valid       <= 1'b1;
      end else begin
        gate_in.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    tracker_result_t want;
    if (rst) begin
      result_out.ready <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (gate_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word mask=%h layer=%h count=%h", $realtime,
                     result_out.entangled_mask, result_out.layer, result_out.kind_count);
        end else begin
          want = gate_results.pop_front();
          if (result_out.entangled_mask !== want.mask || result_out.layer !== want.layer ||
              result_out.kind_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp mask=%h layer=%h count=%h got mask=%h layer=%h count=%h",
                       $realtime, want.mask, want.layer, want.count,
                       result_out.entangled_mask, result_out.layer, result_out.kind_count);
          end
        end
      end
      // Stall at random, with quiet stretches of steady ready
      if (stall_left > 0) begin
        stall_left--;
        result_out.ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        result_out.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 10) stall_left = pick_gap();
        else if ($urandom_range(0, 99) < 2) quiet_left = $urandom_range(50, 300);
        result_out.ready <= (stall_left == 0);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    gate_word_t  w;
    int unsigned r;
    mismatches = 0;
    clear_tables();

    // Directed: reset contents, field extremes, repeats, empty gate, clear
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 0, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 0, 0, 31, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_KIND, 0, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_KIND, 63, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_APPLY, 0, 1, 0, 31, 31));
    pending_gates.push_back(make_gate(OP_APPLY, 63, 2, 31, 0, 31));
    pending_gates.push_back(make_gate(OP_APPLY, 5, 3, 1, 2, 31));
    pending_gates.push_back(make_gate(OP_APPLY, 5, 3, 4, 4, 4));
    pending_gates.push_back(make_gate(OP_APPLY, 7, 2, 5, 5, 0));
    pending_gates.push_back(make_gate(OP_APPLY, 63, 0, 31, 31, 31));
    pending_gates.push_back(make_gate(OP_APPLY, 63, 3, 0, 5, 4));
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 63, 3, 31, 31, 31));
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 0, 0, 4, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 0, 0, 3, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_KIND, 63, 3, 31, 31, 31));
    pending_gates.push_back(make_gate(OP_READ_KIND, 5, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_CLEAR, 63, 3, 31, 31, 31));
    pending_gates.push_back(make_gate(OP_READ_QUBIT, 0, 0, 31, 0, 0));
    pending_gates.push_back(make_gate(OP_READ_KIND, 63, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_APPLY, 0, 0, 0, 0, 0));
    pending_gates.push_back(make_gate(OP_CLEAR, 0, 0, 0, 0, 0));

    // Random: mostly gates on a hot set of qubits to build depth and merges
    for (int i = 0; i < 950; i++) begin
      r = $urandom_range(0, 199);
      w = make_gate(OP_APPLY, $urandom_range(0, 63), 0, 0, 0, 0);
      if (r < 2) w.op = OP_CLEAR;
      else if (r < 42) w.op = OP_READ_QUBIT;
      else if (r < 72) w.op = OP_READ_KIND;
      w.qcount = QCNT_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 1) == 0) begin
        w.qa = QUBIT_W'($urandom_range(0, 7));
        w.qb = QUBIT_W'($urandom_range(0, 7));
        w.qc = QUBIT_W'($urandom_range(0, 7));
      end else begin
        w.qa = QUBIT_W'($urandom_range(0, 31));
        w.qb = QUBIT_W'($urandom_range(0, 31));
        w.qc = QUBIT_W'($urandom_range(0, 31));
      end
      if ($urandom_range(0, 3) == 0) w.kind = KIND_W'($urandom_range(0, 3));
      w.drain = (i == 475);
      pending_gates.push_back(w);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_gates.size() == 0);
    @(posedge clk);
    wait (!gate_in.valid);
    wait (gate_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && gate_results.size() == 0) begin
      $display("gate_stream_depth_and_entanglement verification clean");
    end else begin
      $display("gate_stream_depth_and_entanglement verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("gate_stream_depth_and_entanglement verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/gsde_pkg.sv
hdl/gsde_if.sv
hdl/gsde_lane.sv
hdl/gsde_merge.sv
hdl/gsde_kind_mem.sv
hdl/gate_stream_depth_and_entanglement.sv
bench/gate_stream_depth_and_entanglement_tb.sv
